@@ rtl/tmb_pkg.sv @@
// Shared types and constants for the timer bank.
// Holds the command and event codes, the queued request record and default sizes.
// No dependencies; every other file of the block uses it.
`default_nettype none

package tmb_pkg;

   // Default sizes handed down from the top level.
   localparam int NUM_SLOTS_DEF  = 16;
   localparam int TIME_WIDTH_DEF = 32;

   // Fixed field widths of the request and response channels.
   localparam int DELTA_W     = 16;
   localparam int DURATION_W  = 32;
   localparam int SLOT_ID_W   = 4;
   localparam int REQ_TDATA_W = 56;
   localparam int REQ_TUSER_W = 2;
   localparam int RSP_TDATA_W = 8;
   localparam int RSP_TUSER_W = 3;

   // Request commands.
   typedef enum logic [1:0] {
      CMD_TICK   = 2'd0,
      CMD_ADD    = 2'd1,
      CMD_REMOVE = 2'd2,
      CMD_CLEAR  = 2'd3
   } cmd_type;

   // Response event codes.
   typedef enum logic [2:0] {
      EV_ADDED     = 3'd0,
      EV_FULL      = 3'd1,
      EV_FIRED     = 3'd2,
      EV_TICK_DONE = 3'd3,
      EV_DONE      = 3'd4
   } event_type;

   // One classified request as it waits in the queue.
   typedef struct packed {
      cmd_type                 cmd;
      logic [DELTA_W-1:0]      delta;
      logic [DURATION_W-1:0]   duration;
      logic                    periodic;
      logic [SLOT_ID_W-1:0]    slot_id;
      logic                    rm_in_range;
   } req_type;

   // Execution states of the back end.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ADD_SCAN,
      ST_TICK_READ,
      ST_TICK_SUM,
      ST_TICK_CHECK,
      ST_TICK_DONE
   } back_state_type;

endpackage

`default_nettype wire

@@ rtl/tmb_front.sv @@
// Front end of the timer bank: accepts requests, classifies them and queues them.
// Uses tmb_pkg for the request record and the command codes.
// Feeds a two-entry queue that the back end drains.
`default_nettype none

module tmb_front #(
   parameter int NUM_SLOTS = tmb_pkg::NUM_SLOTS_DEF
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_tvalid,
   output logic                                req_tready,
   // tdata: delta[15:0], duration[47:16], periodic[48], slot_id[52:49], zero fill
   input  wire logic [tmb_pkg::REQ_TDATA_W-1:0] req_tdata,
   // tuser: command[1:0]
   input  wire logic [tmb_pkg::REQ_TUSER_W-1:0] req_tuser,
   output logic                                q_valid,
   output tmb_pkg::req_type                    q_data,
   input  wire logic                           q_pop
);

   localparam int IDX_W = $clog2(NUM_SLOTS);
   localparam int CMP_W = ((IDX_W > tmb_pkg::SLOT_ID_W) ? IDX_W : tmb_pkg::SLOT_ID_W) + 1;

   tmb_pkg::req_type q_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;
   tmb_pkg::req_type req_class;
   logic             push;

   // Unpack the request and decide whether a remove targets an existing slot.
   always_comb begin
      req_class.cmd         = tmb_pkg::cmd_type'(req_tuser);
      req_class.delta       = req_tdata[15:0];
      req_class.duration    = req_tdata[47:16];
      req_class.periodic    = req_tdata[48];
      req_class.slot_id     = req_tdata[52:49];
      req_class.rm_in_range = CMP_W'(req_tdata[52:49]) < CMP_W'(NUM_SLOTS);
   end

   assign req_tready = (count_ff != 2'd2);
   assign push       = req_tvalid && req_tready;
   assign q_valid    = (count_ff != 2'd0);
   assign q_data     = q_ff[rd_ptr_ff];

   // Queue pointers and fill count.
   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ q_pop;
      count_in  = count_ff;
      if (push && !q_pop) begin
         count_in = count_ff + 2'd1;
      end else if (!push && q_pop) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage holds payload only.
   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= req_class;
      end
   end

endmodule

`default_nettype wire

@@ rtl/tmb_back.sv @@
// Back end of the timer bank: executes queued requests against the slot state.
// Uses tmb_pkg; holds the flag bits, the elapsed and period memories and the
// response register.
`default_nettype none

module tmb_back #(
   parameter int NUM_SLOTS  = tmb_pkg::NUM_SLOTS_DEF,
   parameter int TIME_WIDTH = tmb_pkg::TIME_WIDTH_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            q_valid,
   input  wire tmb_pkg::req_type                q_data,
   output logic                                 q_pop,
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   // tdata: timer_id[3:0], zero fill
   output logic [tmb_pkg::RSP_TDATA_W-1:0]      rsp_tdata,
   // tuser: event_res[2:0]
   output logic [tmb_pkg::RSP_TUSER_W-1:0]      rsp_tuser,
   output logic                                 rsp_tlast
);

   localparam int IDX_W = $clog2(NUM_SLOTS);
   localparam int SUM_W = ((TIME_WIDTH > tmb_pkg::DELTA_W) ? TIME_WIDTH : tmb_pkg::DELTA_W) + 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SLOTS - 1);

   tmb_pkg::back_state_type state_ff, state_in;
   logic [IDX_W-1:0]        idx_ff, idx_in;
   logic [NUM_SLOTS-1:0]    active_ff, active_in;
   logic [NUM_SLOTS-1:0]    pend_ff, pend_in;
   logic [NUM_SLOTS-1:0]    reload_ff, reload_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   tmb_pkg::event_type      rsp_event_ff;
   logic [3:0]              rsp_id_ff;
   logic                    rsp_last_ff;
   logic [TIME_WIDTH-1:0]   sum_ff, sum_in;
   logic [TIME_WIDTH-1:0]   elap_rd_ff;
   logic [TIME_WIDTH-1:0]   per_rd_ff;

   // Slot memories: written and read at the current scan index.
   logic [TIME_WIDTH-1:0]   elapsed_mem [NUM_SLOTS];
   logic [TIME_WIDTH-1:0]   period_mem  [NUM_SLOTS];

   logic                    out_free;
   logic                    emit;
   tmb_pkg::event_type      emit_event;
   logic [3:0]              emit_id;
   logic                    emit_last;
   logic                    we_elap;
   logic                    we_per;
   logic [TIME_WIDTH-1:0]   elap_wd;
   logic [TIME_WIDTH-1:0]   per_wd;
   logic [IDX_W-1:0]        rm_idx;
   logic                    slot_free;
   logic                    slot_run;
   logic [SUM_W-1:0]        sum_wide;
   logic [TIME_WIDTH-1:0]   sum_sat;
   logic                    hit;

   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign rm_idx    = IDX_W'(q_data.slot_id);
   assign slot_free = !active_ff[idx_ff] && !pend_ff[idx_ff];
   assign slot_run  = active_ff[idx_ff] && !pend_ff[idx_ff];

   // Saturating add of the tick delta to the elapsed time read from memory.
   assign sum_wide = SUM_W'(elap_rd_ff) + SUM_W'(q_data.delta);
   assign sum_sat  = (|sum_wide[SUM_W-1:TIME_WIDTH]) ? '1 : sum_wide[TIME_WIDTH-1:0];

   // The registered sum is compared with the period in the next cycle.
   assign hit = (sum_ff >= per_rd_ff);

   // Sequencer: next state, flag updates, memory writes and responses.
   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      active_in    = active_ff;
      pend_in      = pend_ff;
      reload_in    = reload_ff;
      sum_in       = sum_ff;
      q_pop        = 1'b0;
      emit         = 1'b0;
      emit_event   = tmb_pkg::EV_DONE;
      emit_id      = 4'd0;
      emit_last    = 1'b1;
      we_elap      = 1'b0;
      we_per       = 1'b0;
      elap_wd      = sum_ff;
      per_wd       = TIME_WIDTH'(q_data.duration);

      unique case (state_ff)
         tmb_pkg::ST_IDLE: begin
            if (q_valid) begin
               unique case (q_data.cmd)
                  tmb_pkg::CMD_TICK: begin
                     idx_in   = '0;
                     state_in = tmb_pkg::ST_TICK_READ;
                  end
                  tmb_pkg::CMD_ADD: begin
                     idx_in   = '0;
                     state_in = tmb_pkg::ST_ADD_SCAN;
                  end
                  tmb_pkg::CMD_REMOVE: begin
                     if (out_free) begin
                        if (q_data.rm_in_range && active_ff[rm_idx]) begin
                           pend_in[rm_idx] = 1'b1;
                        end
                        emit  = 1'b1;
                        q_pop = 1'b1;
                     end
                  end
                  tmb_pkg::CMD_CLEAR: begin
                     if (out_free) begin
                        active_in = '0;
                        pend_in   = '0;
                        emit      = 1'b1;
                        q_pop     = 1'b1;
                     end
                  end
               endcase
            end
         end

         // Walk the slots from the lowest id until a free one turns up or the last one is taken.
         tmb_pkg::ST_ADD_SCAN: begin
            if (slot_free) begin
               if (out_free) begin
                  active_in[idx_ff] = 1'b1;
                  reload_in[idx_ff] = q_data.periodic;
                  we_per            = 1'b1;
                  we_elap           = 1'b1;
                  elap_wd           = '0;
                  emit              = 1'b1;
                  emit_event        = tmb_pkg::EV_ADDED;
                  emit_id           = 4'(idx_ff);
                  q_pop             = 1'b1;
                  state_in          = tmb_pkg::ST_IDLE;
               end
            end else if (idx_ff == LAST_IDX) begin
               if (out_free) begin
                  emit       = 1'b1;
                  emit_event = tmb_pkg::EV_FULL;
                  q_pop      = 1'b1;
                  state_in   = tmb_pkg::ST_IDLE;
               end
            end else begin
               idx_in = idx_ff + IDX_W'(1);
            end
         end

         // Skip slots that are idle or pending; a running slot starts its read.
         tmb_pkg::ST_TICK_READ: begin
            if (slot_run) begin
               state_in = tmb_pkg::ST_TICK_SUM;
            end else if (idx_ff == LAST_IDX) begin
               state_in = tmb_pkg::ST_TICK_DONE;
            end else begin
               idx_in = idx_ff + IDX_W'(1);
            end
         end

         tmb_pkg::ST_TICK_SUM: begin
            sum_in   = sum_sat;
            state_in = tmb_pkg::ST_TICK_CHECK;
         end

         // Write back the new elapsed time and report a firing slot.
         tmb_pkg::ST_TICK_CHECK: begin
            if (!hit || out_free) begin
               we_elap = 1'b1;
               if (hit) begin
                  emit       = 1'b1;
                  emit_event = tmb_pkg::EV_FIRED;
                  emit_id    = 4'(idx_ff);
                  emit_last  = 1'b0;
                  if (reload_ff[idx_ff]) begin
                     elap_wd = '0;
                  end else begin
                     pend_in[idx_ff] = 1'b1;
                  end
               end
               if (idx_ff == LAST_IDX) begin
                  state_in = tmb_pkg::ST_TICK_DONE;
               end else begin
                  idx_in   = idx_ff + IDX_W'(1);
                  state_in = tmb_pkg::ST_TICK_READ;
               end
            end
         end

         // Free every pending slot and close the tick.
         tmb_pkg::ST_TICK_DONE: begin
            if (out_free) begin
               active_in  = active_ff & ~pend_ff;
               pend_in    = '0;
               emit       = 1'b1;
               emit_event = tmb_pkg::EV_TICK_DONE;
               q_pop      = 1'b1;
               state_in   = tmb_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = tmb_pkg::ST_IDLE;
         end
      endcase
   end

   // Response register: loads when empty or being taken.
   assign rsp_valid_in = emit || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tmb_pkg::ST_IDLE;
         idx_ff       <= '0;
         active_ff    <= '0;
         pend_ff      <= '0;
         reload_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         active_ff    <= active_in;
         pend_ff      <= pend_in;
         reload_ff    <= reload_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      sum_ff <= sum_in;
      if (emit) begin
         rsp_event_ff <= emit_event;
         rsp_id_ff    <= emit_id;
         rsp_last_ff  <= emit_last;
      end
   end

   // Slot memories with registered read data.
   always_ff @(posedge clock) begin
      if (we_elap) begin
         elapsed_mem[idx_ff] <= elap_wd;
      end
      if (we_per) begin
         period_mem[idx_ff] <= per_wd;
      end
      elap_rd_ff <= elapsed_mem[idx_ff];
      per_rd_ff  <= period_mem[idx_ff];
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = tmb_pkg::RSP_TDATA_W'(rsp_id_ff);
   assign rsp_tuser  = rsp_event_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

`default_nettype wire

@@ rtl/multi_channel_software_timer_bank.sv @@
// Timer bank of NUM_SLOTS one-shot or periodic timers with a stream request port
// and a stream response port. Requests are queued two deep in front, so the
// request side keeps flowing while a response waits, until both entries fill. An
// add walks the slots from id zero, one per cycle. A tick walks every slot through
// the slot memory: an idle or pending slot is skipped, and a running one is read,
// added to, then compared and written back; the tick is then closed. Remove and
// clear are done straight from idle. A stalled response port holds the walk only
// at a slot whose response is due.
// Uses tmb_pkg, tmb_front and tmb_back.
`default_nettype none

module multi_channel_software_timer_bank #(
   parameter int NUM_SLOTS  = tmb_pkg::NUM_SLOTS_DEF,
   parameter int TIME_WIDTH = tmb_pkg::TIME_WIDTH_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   // tdata: delta[15:0], duration[47:16], periodic[48], slot_id[52:49], zero fill
   input  wire logic [tmb_pkg::REQ_TDATA_W-1:0] req_tdata,
   // tuser: command[1:0]
   input  wire logic [tmb_pkg::REQ_TUSER_W-1:0] req_tuser,
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   // tdata: timer_id[3:0], zero fill
   output logic [tmb_pkg::RSP_TDATA_W-1:0]      rsp_tdata,
   // tuser: event_res[2:0]
   output logic [tmb_pkg::RSP_TUSER_W-1:0]      rsp_tuser,
   output logic                                 rsp_tlast
);

   logic             q_valid;
   tmb_pkg::req_type q_data;
   logic             q_pop;

   // Request intake and queue.
   tmb_front #(
      .NUM_SLOTS (NUM_SLOTS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_valid    (q_valid),
      .q_data     (q_data),
      .q_pop      (q_pop)
   );

   // Request execution and responses.
   tmb_back #(
      .NUM_SLOTS  (NUM_SLOTS),
      .TIME_WIDTH (TIME_WIDTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_data     (q_data),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

`default_nettype wire

@@ rtl/tmb_checker.sv @@
// Port-level checks for the timer bank, bound to the top level.
// Uses tmb_pkg for the event codes.
`default_nettype none

module tmb_checker (
   input wire logic                            clock,
   input wire logic                            reset,
   input wire logic                            rsp_tvalid,
   input wire logic                            rsp_tready,
   input wire logic [tmb_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input wire logic [tmb_pkg::RSP_TUSER_W-1:0] rsp_tuser,
   input wire logic                            rsp_tlast
);

   // No response is offered right after reset.
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid right after reset");

   // A stalled response holds its contents.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("stalled response changed");

   // Only a fired event continues a request; every other event closes it.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tlast == (rsp_tuser != tmb_pkg::EV_FIRED)))
      else $error("last flag does not match event");

   // Events without a slot carry a zero id.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == tmb_pkg::EV_FULL || rsp_tuser == tmb_pkg::EV_TICK_DONE ||
                     rsp_tuser == tmb_pkg::EV_DONE) |-> (rsp_tdata == '0))
      else $error("nonzero id on an event without a slot");

   // Event codes stay within the defined set.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser <= tmb_pkg::EV_DONE))
      else $error("undefined event code");

endmodule

bind multi_channel_software_timer_bank tmb_checker u_tmb_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

`default_nettype wire

@@ dv/tmb_event_checker.sv @@
// Event checker for the timer bank: watches the request and response streams,
// predicts the events of every accepted request and compares them in order.
// Depends on tmb_pkg for the command and event codes and the channel widths.
`timescale 1ns / 1ps

module tmb_event_checker (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_tvalid,
   input  wire logic                            req_tready,
   // tdata: delta[15:0], duration[47:16], periodic[48], slot_id[52:49], zero fill
   input  wire logic [tmb_pkg::REQ_TDATA_W-1:0] req_tdata,
   // tuser: command[1:0]
   input  wire logic [tmb_pkg::REQ_TUSER_W-1:0] req_tuser,
   input  wire logic                            rsp_tvalid,
   input  wire logic                            rsp_tready,
   // tdata: timer_id[3:0], zero fill
   input  wire logic [tmb_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   // tuser: event_res[2:0]
   input  wire logic [tmb_pkg::RSP_TUSER_W-1:0] rsp_tuser,
   input  wire logic                            rsp_tlast,
   output int                                   fail_count,
   output int                                   events_owed
);
   import tmb_pkg::*;

   localparam int SLOTS = NUM_SLOTS_DEF;

   // One response as the bank should send it.
   typedef struct packed {
      event_type  ev;
      logic [3:0] id;
      logic       last;
   } timer_event_type;

   // Shadow copy of the slot state.
   logic        armed    [SLOTS];
   logic        retiring [SLOTS];
   logic        reloads  [SLOTS];
   logic [31:0] elapsed  [SLOTS];
   logic [31:0] period   [SLOTS];

   timer_event_type expected_events[$];

   initial fail_count = 0;

   task automatic report_mismatch(input string msg);
      $display("%0t checker: %s", $realtime, msg);
      fail_count++;
   endtask

   function automatic void queue_event(input event_type ev, input logic [3:0] id,
                                       input logic last);
      timer_event_type e;
      e.ev   = ev;
      e.id   = id;
      e.last = last;
      expected_events.push_back(e);
   endfunction

   // Applies one request to the shadow state and queues the events it causes.
   task automatic predict_events(input cmd_type cmd, input logic [15:0] delta,
                                 input logic [31:0] duration, input logic periodic,
                                 input logic [3:0] slot);
      int          i;
      int          free_slot;
      logic [32:0] sum;
      free_slot = -1;
      case (cmd)
         CMD_TICK: begin
            for (i = 0; i < SLOTS; i++) begin
               if (armed[i] && !retiring[i]) begin
                  sum = {1'b0, elapsed[i]} + {17'd0, delta};
                  elapsed[i] = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
                  if (elapsed[i] >= period[i]) begin
                     queue_event(EV_FIRED, 4'(i), 1'b0);
                     if (reloads[i])
                        elapsed[i] = '0;
                     else
                        retiring[i] = 1'b1;
                  end
               end
            end
            // Slots marked for removal leave the bank at the end of the tick.
            for (i = 0; i < SLOTS; i++) begin
               if (retiring[i]) begin
                  armed[i]    = 1'b0;
                  retiring[i] = 1'b0;
               end
            end
            queue_event(EV_TICK_DONE, 4'd0, 1'b1);
         end
         CMD_ADD: begin
            for (i = SLOTS - 1; i >= 0; i--) begin
               if (!armed[i] && !retiring[i])
                  free_slot = i;
            end
            if (free_slot >= 0) begin
               armed[free_slot]   = 1'b1;
               reloads[free_slot] = periodic;
               period[free_slot]  = duration;
               elapsed[free_slot] = '0;
               queue_event(EV_ADDED, 4'(free_slot), 1'b1);
            end else begin
               queue_event(EV_FULL, 4'd0, 1'b1);
            end
         end
         CMD_REMOVE: begin
            if (armed[slot])
               retiring[slot] = 1'b1;
            queue_event(EV_DONE, 4'd0, 1'b1);
         end
         default: begin
            for (i = 0; i < SLOTS; i++) begin
               armed[i]    = 1'b0;
               retiring[i] = 1'b0;
            end
            queue_event(EV_DONE, 4'd0, 1'b1);
         end
      endcase
   endtask

   // Requests are predicted before responses are matched at the same edge.
   always @(posedge clock) begin
      timer_event_type want;
      if (reset) begin
         for (int i = 0; i < SLOTS; i++) begin
            armed[i]    = 1'b0;
            retiring[i] = 1'b0;
            reloads[i]  = 1'b0;
         end
         expected_events.delete();
      end else begin
         if (req_tvalid && req_tready)
            predict_events(cmd_type'(req_tuser), req_tdata[15:0], req_tdata[47:16],
                           req_tdata[48], req_tdata[52:49]);
         if (rsp_tvalid && rsp_tready) begin
            if (expected_events.size() == 0) begin
               report_mismatch($sformatf("unexpected response event %0d id %0d",
                                         rsp_tuser, rsp_tdata[3:0]));
            end else begin
               want = expected_events.pop_front();
               if (rsp_tuser != want.ev)
                  report_mismatch($sformatf("event %0d, wanted %0d", rsp_tuser, want.ev));
               if (rsp_tdata[3:0] != want.id)
                  report_mismatch($sformatf("timer id %0d, wanted %0d",
                                            rsp_tdata[3:0], want.id));
               if (rsp_tlast != want.last)
                  report_mismatch($sformatf("last %0b, wanted %0b", rsp_tlast, want.last));
            end
         end
      end
      events_owed <= expected_events.size();
   end

endmodule

@@ dv/tb.sv @@
// Top of the timer bank testbench: clock, reset, request stimulus and verdict.
// Instantiates multi_channel_software_timer_bank and tmb_event_checker; uses tmb_pkg.
`timescale 1ns / 1ps

module tb;
   import tmb_pkg::*;

   localparam int CYCLE_LIMIT = 400000;

   logic                   clock;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   logic [REQ_TUSER_W-1:0] req_tuser  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic [RSP_TUSER_W-1:0] rsp_tuser;
   logic                   rsp_tlast;

   int fail_count;
   int events_owed;
   int cycle_count   = 0;
   int send_idle_pct = 25;
   int recv_idle_pct = 45;

   multi_channel_software_timer_bank DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   tmb_event_checker checker_inst (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .fail_count  (fail_count),
      .events_owed (events_owed)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // The response side stalls at random.
   always @(posedge clock) begin
      rsp_tready <= !reset && ($urandom_range(99) >= recv_idle_pct);
   end

   // Watchdog for a hung bank or a lost response.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // Presents one request, with random idle cycles first, and waits for acceptance.
   task automatic issue_request(input cmd_type cmd, input logic [15:0] delta,
                                input logic [31:0] duration, input logic periodic,
                                input logic [3:0] slot);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {3'b000, slot, periodic, duration, delta};
      do
         @(posedge clock);
      while (!req_tready);
   endtask

   initial begin
      int          n;
      int          pick;
      cmd_type     cmd;
      logic [15:0] delta;
      logic [31:0] duration;

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part: empty tick, zero duration, one-shot expiry, removes, full bank.
      issue_request(CMD_TICK, 16'd0, 32'd0, 1'b0, 4'd0);
      issue_request(CMD_ADD, 16'd0, 32'd0, 1'b1, 4'd0);
      issue_request(CMD_ADD, 16'd0, 32'd5, 1'b0, 4'd0);
      issue_request(CMD_TICK, 16'd5, 32'd0, 1'b0, 4'd0);
      issue_request(CMD_REMOVE, 16'd0, 32'd0, 1'b0, 4'd15);
      issue_request(CMD_ADD, 16'hFFFF, 32'hFFFF_FFFF, 1'b1, 4'd15);
      issue_request(CMD_REMOVE, 16'd0, 32'd0, 1'b0, 4'd1);
      issue_request(CMD_REMOVE, 16'd0, 32'd0, 1'b0, 4'd1);
      // Slot one is pending removal here, so this add must skip it.
      issue_request(CMD_ADD, 16'd0, 32'd3, 1'b0, 4'd0);
      issue_request(CMD_TICK, 16'hFFFF, 32'hFFFF_FFFF, 1'b1, 4'd15);
      for (n = 0; n < 16; n++)
         issue_request(CMD_ADD, 16'd0, 32'd1000 + n, n[0], 4'd0);
      issue_request(CMD_CLEAR, 16'hFFFF, 32'hFFFF_FFFF, 1'b1, 4'd15);

      // Random part in three idling phases.
      for (n = 0; n < 270; n++) begin
         if (n == 90) begin
            send_idle_pct = 45;
            recv_idle_pct = 25;
         end else if (n == 180) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         pick = $urandom_range(99);
         if (pick < 40)
            cmd = CMD_TICK;
         else if (pick < 75)
            cmd = CMD_ADD;
         else if (pick < 96)
            cmd = CMD_REMOVE;
         else
            cmd = CMD_CLEAR;
         delta = ($urandom_range(9) < 7) ? 16'($urandom_range(100)) : 16'($urandom);
         pick = $urandom_range(9);
         if (pick == 0)
            duration = '0;
         else if (pick < 8)
            duration = 32'($urandom_range(250));
         else
            duration = $urandom;
         issue_request(cmd, delta, duration, 1'($urandom_range(1)),
                       4'($urandom_range(15)));
      end
      req_tvalid <= 1'b0;

      // Let the last prediction land, drain the responses, then a short tail.
      @(posedge clock);
      while (events_owed != 0)
         @(posedge clock);
      repeat (60) @(posedge clock);
      if (fail_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
